/* hw/rtl/csne_pkg.sv */
`default_nettype none
package csne_pkg;
  localparam int unsigned PWidth    = 18;
  localparam int unsigned LenWidth  = 35;
  localparam int unsigned AccWidth  = 72;
  localparam int unsigned RsWidth   = 17;
  localparam int unsigned NumWidth  = 18;
  localparam int unsigned QWidth    = 17;
  localparam int unsigned SrchSteps = 17;

  localparam logic [LenWidth-1:0] DSq     = 35'd4228250625;
  localparam logic [AccWidth-1:0] LimitSq = {37'd0, DSq} << 34;
  localparam logic [18:0]         Bias    = 19'd65280;
  localparam logic [37:0]         BiasQ16 = 38'd65280 << 16;
  localparam logic [15:0]         Recip   = 16'd32896;
  localparam logic [QWidth-1:0]   Div     = 17'd255;

  typedef struct packed {
    logic signed [PWidth-1:0]   px;
    logic signed [PWidth-1:0]   py;
    logic [LenWidth-1:0]        len_sq;
    logic                       is_long;
    logic signed [AccWidth-1:0] acc_s;
    logic signed [AccWidth-1:0] acc_w;
    logic [RsWidth-1:0]         rs;
  } srch_t;
endpackage
`default_nettype wire

/* hw/rtl/coverage_scaled_normal_encode.sv */
// Coverage-scaled two-channel normal re-encoder.
// Input beat: red/green bytes hold a normal (byte/127.5-1), alpha byte
// holds coverage (byte/255). Output beat: both components scaled by
// coverage, renormalized to unit length if longer than one, re-encoded
// as round-half-up bytes.
// Channels use valid/stall; a beat moves when valid is high and stall low.
// The pipeline has 22 register stages and takes one beat per cycle
// while it is not stalled. The reciprocal length is found by a
// 17-stage bit-per-stage search; multiply and divide-by-510 take the rest.
// The whole pipeline advances together; in_stall_o is high while the
// output register holds a beat and out_stall_i is high, so a stall
// drops and repeats nothing.
// Reset clears all valid bits; the data registers are not reset.
`default_nettype none
module coverage_scaled_normal_encode (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] normal_x_byte_i,
  input  wire logic [7:0] normal_y_byte_i,
  input  wire logic [7:0] coverage_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_x_byte_o,
  output logic [7:0]      out_y_byte_o
);
  localparam int unsigned NStg = 22;

  logic [NStg-1:0] vld_q;
  logic            adv;

  assign adv        = !(vld_q[NStg-1] && out_stall_i);
  assign in_stall_o = !adv;
  assign out_valid_o = vld_q[NStg-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NStg-2:0], in_valid_i};
    end
  end

  // stage 1: scaled components
  logic signed [9:0] a_c, b_c;
  logic signed [csne_pkg::PWidth-1:0] px_q, py_q;
  assign a_c = $signed({1'b0, normal_x_byte_i, 1'b0}) - 10'sd255;
  assign b_c = $signed({1'b0, normal_y_byte_i, 1'b0}) - 10'sd255;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      px_q <= csne_pkg::PWidth'(a_c * $signed({1'b0, coverage_byte_i}));
      py_q <= csne_pkg::PWidth'(b_c * $signed({1'b0, coverage_byte_i}));
    end
  end

  // stage 2: squared length
  logic signed [35:0] sqx_c, sqy_c;
  logic [csne_pkg::LenWidth-1:0] len_c;
  assign sqx_c = px_q * px_q;
  assign sqy_c = py_q * py_q;
  assign len_c = csne_pkg::LenWidth'(sqx_c) + csne_pkg::LenWidth'(sqy_c);

  csne_pkg::srch_t srch_q [csne_pkg::SrchSteps+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      srch_q[0].px      <= px_q;
      srch_q[0].py      <= py_q;
      srch_q[0].len_sq  <= len_c;
      srch_q[0].is_long <= len_c > csne_pkg::DSq;
      srch_q[0].acc_s   <= $signed({37'd0, len_c});
      srch_q[0].acc_w   <= -$signed({37'd0, len_c});
      srch_q[0].rs      <= '0;
    end
  end

  // reciprocal length search, one bit per stage, MSB first.
  // acc_s = u^2*m, acc_w = k*u*m with u = (2*rs-1)*k, m = a^2+b^2.
  for (genvar i = 0; i < csne_pkg::SrchSteps; i++) begin : g_srch
    localparam int unsigned Bit = csne_pkg::SrchSteps - 1 - i;
    logic signed [csne_pkg::AccWidth-1:0] len_s, s_cand, w_cand;
    logic take;
    assign len_s  = $signed({37'd0, srch_q[i].len_sq});
    assign s_cand = srch_q[i].acc_s + (srch_q[i].acc_w <<< (Bit + 2))
                    + (len_s <<< (2 * Bit + 2));
    assign w_cand = srch_q[i].acc_w + (len_s <<< (Bit + 1));
    assign take   = s_cand <= $signed(csne_pkg::LimitSq);

    always_ff @(posedge clk_i) begin
      if (adv) begin
        srch_q[i+1].px      <= srch_q[i].px;
        srch_q[i+1].py      <= srch_q[i].py;
        srch_q[i+1].len_sq  <= srch_q[i].len_sq;
        srch_q[i+1].is_long <= srch_q[i].is_long;
        srch_q[i+1].acc_s   <= take ? s_cand : srch_q[i].acc_s;
        srch_q[i+1].acc_w   <= take ? w_cand : srch_q[i].acc_w;
        srch_q[i+1].rs      <= srch_q[i].rs
                               | (take ? csne_pkg::RsWidth'(1) << Bit : '0);
      end
    end
  end

  // encode numerator
  csne_pkg::srch_t last;
  assign last = srch_q[csne_pkg::SrchSteps];

  logic [csne_pkg::NumWidth-1:0] numx_q, numy_q;

  function automatic logic [csne_pkg::NumWidth-1:0] enc_num(
    input logic signed [csne_pkg::PWidth-1:0] p,
    input logic [csne_pkg::RsWidth-1:0]       rs,
    input logic                               is_long
  );
    logic signed [35:0] pr;
    logic signed [37:0] num;
    logic signed [21:0] n2;
    logic signed [18:0] pl;
    pr  = p * $signed({1'b0, rs});
    num = 38'(pr) + $signed(csne_pkg::BiasQ16);
    n2  = 22'(num >>> 16);
    pl  = 19'(p) + $signed(csne_pkg::Bias);
    if (is_long) begin
      enc_num = n2[21] ? '0 : n2[csne_pkg::NumWidth-1:0];
    end else begin
      enc_num = pl[csne_pkg::NumWidth-1:0];
    end
  endfunction

  always_ff @(posedge clk_i) begin
    if (adv) begin
      numx_q <= enc_num(last.px, last.rs, last.is_long);
      numy_q <= enc_num(last.py, last.rs, last.is_long);
    end
  end

  // divide by 510: halve, then reciprocal of 255 with one correction
  logic [csne_pkg::QWidth-1:0] hx_c, hy_c, hx_q, hy_q;
  logic [32:0] prx_c, pry_c;
  logic [9:0]  q0x_q, q0y_q;
  assign hx_c  = numx_q[csne_pkg::NumWidth-1:1];
  assign hy_c  = numy_q[csne_pkg::NumWidth-1:1];
  assign prx_c = hx_c * csne_pkg::Recip;
  assign pry_c = hy_c * csne_pkg::Recip;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hx_q  <= hx_c;
      hy_q  <= hy_c;
      q0x_q <= prx_c[32:23];
      q0y_q <= pry_c[32:23];
    end
  end

  function automatic logic [7:0] fin(
    input logic [csne_pkg::QWidth-1:0] h,
    input logic [9:0]                  q0
  );
    logic [csne_pkg::QWidth-1:0] r;
    logic [9:0] q;
    r = h - csne_pkg::QWidth'(q0) * csne_pkg::Div;
    q = q0 + ((r >= csne_pkg::Div) ? 10'd1 : 10'd0);
    fin = (q > 10'd255) ? 8'd255 : q[7:0];
  endfunction

  logic [7:0] outx_q, outy_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      outx_q <= fin(hx_q, q0x_q);
      outy_q <= fin(hy_q, q0y_q);
    end
  end

  assign out_x_byte_o = outx_q;
  assign out_y_byte_o = outy_q;
endmodule
`default_nettype wire

/* tb/sv/coverage_scaled_normal_encode_tb.sv */
`default_nettype none
module coverage_scaled_normal_encode_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumRandom = 1350;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 40;
  localparam longint DenomD = 65025;

  typedef struct packed {
    logic [7:0] nx;
    logic [7:0] ny;
    logic [7:0] cov;
    logic       known;
    logic [7:0] ex;
    logic [7:0] ey;
  } dir_row_t;

  typedef struct packed {
    logic [7:0] x;
    logic [7:0] y;
  } enc_pair_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] normal_x_byte_i = '0;
  logic [7:0] normal_y_byte_i = '0;
  logic [7:0] coverage_byte_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] out_x_byte_o;
  logic [7:0] out_y_byte_o;

  enc_pair_t pending_pairs[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned beats_in = 0;
  int unsigned beats_out = 0;
  int unsigned long_vectors = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_off = 1'b0;

  coverage_scaled_normal_encode dut (.*);

  always #4 clk_i = ~clk_i;

  function automatic longint unit_recip(longint k, longint msq);
    longint unsigned dsq;
    longint unsigned big;
    longint unsigned m;
    longint unsigned q1;
    longint unsigned r1;
    longint unsigned q;
    longint unsigned t;
    longint lo;
    longint hi;
    longint mid;
    // 2^34 * D^2 overflows 64 bits, so divide in two steps
    dsq = longint'(DenomD) * DenomD;
    m = msq;
    big = dsq << 17;
    q1 = big / m;
    r1 = big % m;
    q = (q1 << 17) + ((r1 << 17) / m);
    lo = 1;
    hi = 65536;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      t = longint'(2 * mid - 1) * k;
      if (t * t <= q) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic logic [7:0] encode_comp(longint p, longint rs, bit is_long);
    longint num;
    longint v;
    if (is_long) begin
      num = p * rs + DenomD * 65536 + 255 * 65536;
      if (num < 0) return 8'd0;
      v = num / (510 * 65536);
    end else begin
      v = (p + DenomD + 255) / 510;
      if (v < 0) v = 0;
    end
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic enc_pair_t predict_encode(logic [7:0] nx, logic [7:0] ny,
                                               logic [7:0] cov);
    longint a;
    longint b;
    longint k;
    longint rs;
    bit is_long;
    enc_pair_t r;
    a = 2 * longint'(nx) - 255;
    b = 2 * longint'(ny) - 255;
    k = longint'(cov);
    is_long = (a * k) * (a * k) + (b * k) * (b * k) > DenomD * DenomD;
    rs = is_long ? unit_recip(k, a * a + b * b) : 0;
    r.x = encode_comp(a * k, rs, is_long);
    r.y = encode_comp(b * k, rs, is_long);
    return r;
  endfunction

  function automatic bit is_long_vec(logic [7:0] nx, logic [7:0] ny, logic [7:0] cov);
    longint a;
    longint b;
    a = (2 * longint'(nx) - 255) * cov;
    b = (2 * longint'(ny) - 255) * cov;
    return a * a + b * b > DenomD * DenomD;
  endfunction

  task automatic send_beat(logic [7:0] nx, logic [7:0] ny, logic [7:0] cov,
                           enc_pair_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    normal_x_byte_i <= nx;
    normal_y_byte_i <= ny;
    coverage_byte_i <= cov;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_pairs.push_back(want);
    beats_in++;
    if (is_long_vec(nx, ny, cov)) long_vectors++;
    @(negedge clk_i);
  endtask

  task automatic send_checked(logic [7:0] nx, logic [7:0] ny, logic [7:0] cov);
    send_beat(nx, ny, cov, predict_encode(nx, ny, cov));
  endtask

  task automatic settle_idle();
    in_valid_i <= 1'b0;
    while (pending_pairs.size() != 0) @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (hold_off) out_stall_i <= 1'b1;
    else out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    enc_pair_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      beats_out++;
      if (pending_pairs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: x=%0d y=%0d", out_x_byte_o, out_y_byte_o);
      end else begin
        want = pending_pairs.pop_front();
        if (want.x !== out_x_byte_o || want.y !== out_y_byte_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                     want.x, want.y, out_x_byte_o, out_y_byte_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("coverage_scaled_normal_encode_tb failed");
      $finish;
    end
  end

  initial begin
    dir_row_t rows[$];
    enc_pair_t want;
    logic [7:0] nx;
    logic [7:0] ny;
    logic [7:0] cov;
    int unsigned sel;
    int unsigned n;

    rows = '{
      '{8'd0,   8'd0,   8'd0,   1'b1, 8'd128, 8'd128},
      '{8'd255, 8'd255, 8'd0,   1'b1, 8'd128, 8'd128},
      '{8'd37,  8'd201, 8'd0,   1'b1, 8'd128, 8'd128},
      '{8'd255, 8'd128, 8'd255, 1'b1, 8'd255, 8'd128},
      '{8'd0,   8'd128, 8'd255, 1'b1, 8'd0,   8'd128},
      '{8'd128, 8'd255, 8'd255, 1'b1, 8'd128, 8'd255},
      '{8'd128, 8'd0,   8'd255, 1'b1, 8'd128, 8'd0},
      '{8'd127, 8'd128, 8'd255, 1'b1, 8'd127, 8'd128},
      '{8'd255, 8'd255, 8'd255, 1'b0, 8'd0,   8'd0},
      '{8'd0,   8'd0,   8'd255, 1'b0, 8'd0,   8'd0},
      '{8'd255, 8'd0,   8'd255, 1'b0, 8'd0,   8'd0},
      '{8'd0,   8'd255, 8'd1,   1'b0, 8'd0,   8'd0},
      '{8'd255, 8'd255, 8'd1,   1'b0, 8'd0,   8'd0},
      '{8'd255, 8'd255, 8'd180, 1'b0, 8'd0,   8'd0},
      '{8'd255, 8'd255, 8'd181, 1'b0, 8'd0,   8'd0},
      '{8'd170, 8'd85,  8'd128, 1'b0, 8'd0,   8'd0},
      '{8'd200, 8'd40,  8'd254, 1'b0, 8'd0,   8'd0},
      '{8'd1,   8'd254, 8'd200, 1'b0, 8'd0,   8'd0},
      '{8'd129, 8'd126, 8'd77,  1'b0, 8'd0,   8'd0},
      '{8'd85,  8'd170, 8'd255, 1'b0, 8'd0,   8'd0}
    };

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) begin
      want = rows[i].known ? enc_pair_t'({rows[i].ex, rows[i].ey})
                           : predict_encode(rows[i].nx, rows[i].ny, rows[i].cov);
      send_beat(rows[i].nx, rows[i].ny, rows[i].cov, want);
    end
    settle_idle();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        3: begin send_idle_pct = 17; recv_stall_pct = 17; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      if (ph == 4) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (120) @(negedge clk_i);
            hold_off = 1'b0;
          end
        join_none
      end
      n = (ph == 4) ? NumRandom / 10 : NumRandom * 9 / 40;
      for (int unsigned j = 0; j < n; j++) begin
        sel = $urandom_range(9);
        nx = 8'($urandom_range(255));
        ny = 8'($urandom_range(255));
        cov = 8'($urandom_range(255));
        if (sel == 0) cov = $urandom_range(1) ? 8'd255 : 8'd0;
        else if (sel == 1) begin
          nx = $urandom_range(1) ? 8'd255 : 8'd0;
          ny = $urandom_range(1) ? 8'd255 : 8'd0;
        end else if (sel == 2) cov = 8'(8'd170 + $urandom_range(20));
        send_checked(nx, ny, cov);
      end
      settle_idle();
    end

    repeat (DrainCycles) @(negedge clk_i);
    $display("sent %0d beats, received %0d, %0d on the unit-length path",
             beats_in, beats_out, long_vectors);
    $display("phases: no idling, sender idle, receiver stall, both, long hold-off");
    if (mismatches == 0 && pending_pairs.size() == 0) begin
      $display("coverage_scaled_normal_encode_tb passed");
    end else begin
      $display("%0d mismatches, %0d beats outstanding", mismatches, pending_pairs.size());
      $display("coverage_scaled_normal_encode_tb failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* coverage_scaled_normal_encode.f */
hw/rtl/csne_pkg.sv
hw/rtl/coverage_scaled_normal_encode.sv
tb/sv/coverage_scaled_normal_encode_tb.sv
